### design/tagged_value_response_parser_core_defines.svh
// Shared assertion macros for the response parser
`ifndef TAGGED_VALUE_RESPONSE_PARSER_CORE_DEFINES_SVH
`define TAGGED_VALUE_RESPONSE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define TVRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define TVRP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tvrp_pkg.sv
package tvrp_pkg;

	// command codes
	localparam logic [1:0] CMD_ARM  = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_COLON = 8'd58;

	localparam logic [4:0] FRAC_MAX = 5'd31;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		NP_WS,
		NP_SIGN,
		NP_INT,
		NP_FRAC,
		NP_FROZEN,
		NP_END
	} numph_t;

	// control flags of one transaction
	typedef struct packed {
		logic   armed;
		phase_t phase;
		logic   colon_seen;
		numph_t nph;
		logic   negative;
		logic   overflowed;
	} flags_t;

	// result control group (mantissa travels beside it)
	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		logic [4:0] frac_digits;
	} res_ctl_t;

endpackage

### design/tvrp_step.sv
module tvrp_step #(
	parameter int BUFFER_CHARS  = 32,
	parameter int MANTISSA_BITS = 32
) (
	input  logic [1:0]                        cmd,
	input  logic [7:0]                        data,
	input  logic [15:0]                       timeout_ticks,
	input  tvrp_pkg::flags_t                  fl,
	input  logic [7:0]                        exp_char,
	input  logic [$clog2(BUFFER_CHARS)-1:0]   count,
	input  logic [MANTISSA_BITS-1:0]          accum,
	input  logic [4:0]                        frac,
	input  logic [15:0]                       elapsed,
	output tvrp_pkg::flags_t                  fl_n,
	output logic [7:0]                        exp_char_n,
	output logic [$clog2(BUFFER_CHARS)-1:0]   count_n,
	output logic [MANTISSA_BITS-1:0]          accum_n,
	output logic [4:0]                        frac_n,
	output logic [15:0]                       elapsed_n,
	output tvrp_pkg::res_ctl_t                res,
	output logic [MANTISSA_BITS-1:0]          res_mant
);
	import tvrp_pkg::*;

	localparam int CNT_W = $clog2(BUFFER_CHARS);
	localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(BUFFER_CHARS - 1);
	localparam logic [MANTISSA_BITS-1:0] LIM = {1'b0, {(MANTISSA_BITS-1){1'b1}}};

	logic                     is_digit;
	logic                     is_ws;
	logic [3:0]               dval;
	logic [MANTISSA_BITS+3:0] acc_ext;
	logic [MANTISSA_BITS+3:0] acc10;
	logic                     over;
	logic [15:0]              el_inc;
	logic                     do_store;
	logic                     run_int;

	// character classes and the times-ten accumulate
	assign is_digit = (data >= CH_ZERO) && (data <= CH_NINE);
	assign is_ws    = (data == CH_SPACE) || ((data >= CH_TAB) && (data <= CH_CR));
	assign dval     = is_digit ? 4'(data - CH_ZERO) : 4'd0;
	assign acc_ext  = {4'b0, accum};
	assign acc10    = (acc_ext << 3) + (acc_ext << 1) + {{MANTISSA_BITS{1'b0}}, dval};
	assign over     = acc10 > {4'b0, LIM};
	assign el_inc   = (elapsed != ELAPSED_MAX) ? elapsed + 16'd1 : elapsed;

	// next state and result for one word
	always_comb begin
		fl_n       = fl;
		exp_char_n = exp_char;
		count_n    = count;
		accum_n    = accum;
		frac_n     = frac;
		elapsed_n  = elapsed;
		res        = '0;
		res_mant   = '0;
		do_store   = 1'b0;
		run_int    = 1'b0;

		case (cmd)
			CMD_ARM: begin
				fl_n       = '{armed: 1'b1, phase: PH_WAIT, colon_seen: 1'b0, nph: NP_WS,
					negative: 1'b0, overflowed: 1'b0};
				exp_char_n = data;
				count_n    = '0;
				accum_n    = '0;
				frac_n     = '0;
				elapsed_n  = '0;
			end
			CMD_TICK: begin
				if (fl.armed) begin
					elapsed_n = el_inc;
					if (el_inc >= timeout_ticks) begin
						fl_n.armed    = 1'b0;
						fl_n.negative = 1'b0;
						res.valid     = 1'b1;
						res.status    = ST_TIMEOUT;
					end
				end
			end
			CMD_BYTE: begin
				if (fl.armed) begin
					case (fl.phase)
						PH_WAIT: begin
							if (data == exp_char) begin
								do_store   = 1'b1;
								fl_n.phase = PH_PAYLOAD;
							end
						end
						PH_PAYLOAD: begin
							if ((data == CH_NL) || (count >= COUNT_LAST)) begin
								fl_n.phase = PH_DONE;
								if (fl.colon_seen) begin
									fl_n.armed      = 1'b0;
									res.valid       = 1'b1;
									res.status      = fl.overflowed ? ST_SAT : ST_OK;
									res.frac_digits = frac;
									res_mant        = fl.negative ? -accum : accum;
								end
							end else begin
								do_store = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		// store one payload byte: find the colon, then parse the number
		if (do_store) begin
			count_n = count + 1'b1;
			if (!fl.colon_seen) begin
				if (fl.nph != NP_END) begin
					if (data == CH_NUL) begin
						fl_n.nph = NP_END;
					end else if (data == CH_COLON) begin
						fl_n.colon_seen = 1'b1;
					end
				end
			end else if (data == CH_NUL) begin
				fl_n.nph = NP_END;
			end else begin
				case (fl.nph)
					NP_WS: begin
						if (is_ws) begin
						end else if ((data == CH_PLUS) || (data == CH_MINUS)) begin
							fl_n.negative = (data == CH_MINUS);
							fl_n.nph      = NP_SIGN;
						end else begin
							run_int = 1'b1;
						end
					end
					NP_SIGN, NP_INT: begin
						run_int = 1'b1;
					end
					NP_FRAC: begin
						if (is_digit) begin
							if (!fl.overflowed) begin
								if ((frac >= FRAC_MAX) || over) begin
									fl_n.nph = NP_FROZEN;
								end else begin
									accum_n = acc10[MANTISSA_BITS-1:0];
									frac_n  = frac + 5'd1;
								end
							end
						end else begin
							fl_n.nph = NP_END;
						end
					end
					NP_FROZEN: begin
						if (!is_digit) begin
							fl_n.nph = NP_END;
						end
					end
					default: begin
					end
				endcase

				// integer digits saturate at the limit
				if (run_int) begin
					if (is_digit) begin
						fl_n.nph = NP_INT;
						if (!fl.overflowed) begin
							if (over) begin
								accum_n         = LIM;
								fl_n.overflowed = 1'b1;
							end else begin
								accum_n = acc10[MANTISSA_BITS-1:0];
							end
						end
					end else if (data == CH_DOT) begin
						fl_n.nph = NP_FRAC;
					end else begin
						fl_n.nph = NP_END;
					end
				end
			end
		end
	end

endmodule

### design/tvrp_out.sv
module tvrp_out #(
	parameter int MANTISSA_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  tvrp_pkg::res_ctl_t                 res,
	input  logic [MANTISSA_BITS-1:0]           res_mant,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [1:0]                         status,
	output logic signed [MANTISSA_BITS-1:0]    mantissa,
	output logic [4:0]                         frac_digits
);
	import tvrp_pkg::*;

	logic                     valid_q;
	logic [1:0]               status_q;
	logic [MANTISSA_BITS-1:0] mant_q;
	logic [4:0]               frac_q;

	// hold the result word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// load the payload
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= res.status;
			mant_q   <= res_mant;
			frac_q   <= res.frac_digits;
		end
	end

	assign out_valid   = valid_q;
	assign status      = status_q;
	assign mantissa    = signed'(mant_q);
	assign frac_digits = frac_q;

endmodule

### design/tagged_value_response_parser_core.sv
// Tagged value response parser.
// Input channel (in_valid/in_ready): one word per cmd/data pair; an arm word
// names the expected type character, byte words carry received characters,
// tick words advance the timeout counter.
// Config channel (cfg_valid/cfg_ready): writes timeout_ticks; always ready.
// It is to be written only while the parser is idle; the user must keep to this, the block does not enforce it.
// Output channel (out_valid/out_ready): status, mantissa, frac_digits; a word
// appears for a payload newline (or full payload) after a colon, or a timeout.
// Path: an accepted word goes into the input register, and its result word
// into the result register, where it is valid, once the receiver is not stalling.
// Throughput: one input word per cycle unless the receiver stalls; the
// per-word update is a single times-ten accumulate and compare between the
// input and result registers.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; further words wait for out_ready.
// Reset: parser disarmed, timeout_ticks back to 1000, no result pending.
`include "tagged_value_response_parser_core_defines.svh"

module tagged_value_response_parser_core #(
	parameter int BUFFER_CHARS  = 32,
	parameter int MANTISSA_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       cmd,
	input  logic [7:0]                       data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [15:0]                      timeout_ticks,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic signed [MANTISSA_BITS-1:0]  mantissa,
	output logic [4:0]                       frac_digits
);
	import tvrp_pkg::*;

	localparam int CNT_W = $clog2(BUFFER_CHARS);
	localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(BUFFER_CHARS - 1);
	localparam logic [MANTISSA_BITS-1:0] LIM = {1'b0, {(MANTISSA_BITS-1){1'b1}}};

	logic                     v_s1;
	logic [1:0]               cmd_s1;
	logic [7:0]               data_s1;
	logic [15:0]              timeout_q;
	flags_t                   flags_q, flags_n;
	logic [7:0]               exp_q, exp_n;
	logic [CNT_W-1:0]         count_q, count_n;
	logic [MANTISSA_BITS-1:0] accum_q, accum_n;
	logic [4:0]               frac_q, frac_n;
	logic [15:0]              elapsed_q, elapsed_n;
	res_ctl_t                 res;
	logic [MANTISSA_BITS-1:0] res_mant;
	logic                     adv;
	logic                     step;
	logic                     load;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = !v_s1 || adv;
	assign step      = v_s1 && adv;
	assign load      = step && res.valid;
	assign cfg_ready = 1'b1;

	// capture the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= timeout_ticks;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd;
			data_s1 <= data;
		end
	end

	// parser state, advanced once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '{armed: 1'b0, phase: PH_WAIT, colon_seen: 1'b0, nph: NP_WS,
				negative: 1'b0, overflowed: 1'b0};
			exp_q     <= '0;
			count_q   <= '0;
			accum_q   <= '0;
			frac_q    <= '0;
			elapsed_q <= '0;
		end else if (step) begin
			flags_q   <= flags_n;
			exp_q     <= exp_n;
			count_q   <= count_n;
			accum_q   <= accum_n;
			frac_q    <= frac_n;
			elapsed_q <= elapsed_n;
		end
	end

	tvrp_step #(
		.BUFFER_CHARS  (BUFFER_CHARS),
		.MANTISSA_BITS (MANTISSA_BITS)
	) u_step (
		.cmd           (cmd_s1),
		.data          (data_s1),
		.timeout_ticks (timeout_q),
		.fl            (flags_q),
		.exp_char      (exp_q),
		.count         (count_q),
		.accum         (accum_q),
		.frac          (frac_q),
		.elapsed       (elapsed_q),
		.fl_n          (flags_n),
		.exp_char_n    (exp_n),
		.count_n       (count_n),
		.accum_n       (accum_n),
		.frac_n        (frac_n),
		.elapsed_n     (elapsed_n),
		.res           (res),
		.res_mant      (res_mant)
	);

	tvrp_out #(
		.MANTISSA_BITS (MANTISSA_BITS)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.res         (res),
		.res_mant    (res_mant),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.mantissa    (mantissa),
		.frac_digits (frac_digits)
	);

	// checks on the parser state and the result word
	`TVRP_ASSERT_IMP(a_count_bound, 1'b1, count_q <= COUNT_LAST, "stored count past buffer")
	`TVRP_ASSERT_IMP(a_accum_bound, 1'b1, accum_q <= LIM, "accumulator above limit")
	`TVRP_ASSERT_NXT(a_disarm, load, !flags_q.armed, "parser still armed after result")
	`TVRP_ASSERT_IMP(a_timeout_zero, out_valid && (status == ST_TIMEOUT),
		(mantissa == '0) && (frac_digits == '0), "timeout result not zero")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import tvrp_pkg::*;

	localparam int BUFFER_CHARS = 32;
	localparam logic [63:0] MANT_MAX = 64'h7FFF_FFFF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned WORDS_PER_PHASE = 225;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] data;
	} rx_word_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] mantissa;
		logic [4:0]  frac_digits;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd = CMD_TICK;
	logic [7:0]         data = 8'd0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        timeout_ticks = TIMEOUT_RESET;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] mantissa;
	logic [4:0]         frac_digits;

	// words waiting to be sent and readings waiting to come back
	rx_word_t    words_to_send[$];
	reading_t    readings_due[$];
	rx_word_t    next_word;
	reading_t    due;
	int unsigned queued = 0;
	int unsigned errors = 0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	logic        hold_go = 1'b0;
	logic        hold_done = 1'b0;
	logic        calm = 1'b0;

	logic [15:0] timeout_plan [7] = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd7, 16'd25, 16'd3};

	// parser state as predicted from the accepted words
	logic [15:0] tmo_setting = TIMEOUT_RESET;
	logic        rsp_armed = 1'b0;
	logic [7:0]  rsp_tag = 8'd0;
	phase_t      rsp_phase = PH_WAIT;
	logic [4:0]  rsp_kept = 5'd0;
	logic        rsp_colon = 1'b0;
	numph_t      rsp_num = NP_WS;
	logic        rsp_neg = 1'b0;
	logic [63:0] rsp_mag = 64'd0;
	logic [4:0]  rsp_frac = 5'd0;
	logic        rsp_sat = 1'b0;
	logic [15:0] rsp_ticks = 16'd0;

	tagged_value_response_parser_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.data         (data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.timeout_ticks(timeout_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.mantissa     (mantissa),
		.frac_digits  (frac_digits)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// value prediction
	// ---------------------------------------------------------------

	task automatic restart_parse();
		rsp_phase = PH_WAIT;
		rsp_kept = 5'd0;
		rsp_colon = 1'b0;
		rsp_num = NP_WS;
		rsp_neg = 1'b0;
		rsp_mag = 64'd0;
		rsp_frac = 5'd0;
		rsp_sat = 1'b0;
		rsp_ticks = 16'd0;
	endtask

	task automatic post_value(input logic [1:0] st, input logic [63:0] mag,
			input logic [4:0] fd);
		reading_t r;
		r.status = st;
		r.mantissa = rsp_neg ? -mag[31:0] : mag[31:0];
		r.frac_digits = fd;
		readings_due.push_back(r);
		rsp_armed = 1'b0;
	endtask

	// one character of the number text after the colon
	task automatic scan_number(input logic [7:0] b);
		logic        is_digit;
		logic [63:0] dv;
		logic [63:0] room;
		is_digit = (b >= CH_ZERO && b <= CH_NINE);
		dv = is_digit ? 64'(b - CH_ZERO) : 64'd0;
		room = (MANT_MAX - dv) / 10;
		// skip leading whitespace, take one sign
		if (rsp_num == NP_WS) begin
			if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
				return;
			if (b == CH_PLUS || b == CH_MINUS) begin
				rsp_neg = (b == CH_MINUS);
				rsp_num = NP_SIGN;
				return;
			end
		end
		case (rsp_num)
		NP_WS, NP_SIGN, NP_INT: begin
			if (is_digit) begin
				rsp_num = NP_INT;
				if (!rsp_sat) begin
					if (rsp_mag > room) begin
						rsp_mag = MANT_MAX;
						rsp_sat = 1'b1;
					end else begin
						rsp_mag = rsp_mag * 10 + dv;
					end
				end
			end else if (b == CH_DOT) begin
				rsp_num = NP_FRAC;
			end else begin
				rsp_num = NP_END;
			end
		end
		NP_FRAC: begin
			if (is_digit) begin
				if (!rsp_sat) begin
					// truncate the fraction once it no longer fits
					if (rsp_frac >= FRAC_MAX || rsp_mag > room) begin
						rsp_num = NP_FROZEN;
					end else begin
						rsp_mag = rsp_mag * 10 + dv;
						rsp_frac = rsp_frac + 5'd1;
					end
				end
			end else begin
				rsp_num = NP_END;
			end
		end
		NP_FROZEN: begin
			if (!is_digit)
				rsp_num = NP_END;
		end
		default: ;
		endcase
	endtask

	// one character kept in the payload
	task automatic keep_byte(input logic [7:0] b);
		rsp_kept = rsp_kept + 5'd1;
		if (!rsp_colon) begin
			// a NUL ahead of the colon hides everything after it
			if (rsp_num == NP_END)
				return;
			if (b == CH_NUL)
				rsp_num = NP_END;
			else if (b == CH_COLON)
				rsp_colon = 1'b1;
			return;
		end
		if (b == CH_NUL) begin
			rsp_num = NP_END;
			return;
		end
		scan_number(b);
	endtask

	task automatic parse_word(input logic [1:0] c, input logic [7:0] b);
		if (c == CMD_ARM) begin
			restart_parse();
			rsp_armed = 1'b1;
			rsp_tag = b;
			return;
		end
		if (!rsp_armed)
			return;
		if (c == CMD_TICK) begin
			if (rsp_ticks < ELAPSED_MAX)
				rsp_ticks = rsp_ticks + 16'd1;
			if (rsp_ticks >= tmo_setting) begin
				rsp_neg = 1'b0;
				post_value(ST_TIMEOUT, 64'd0, 5'd0);
			end
			return;
		end
		if (c != CMD_BYTE)
			return;
		// hunt for the type character
		if (rsp_phase == PH_WAIT) begin
			if (b == rsp_tag) begin
				keep_byte(b);
				rsp_phase = PH_PAYLOAD;
			end
			return;
		end
		if (rsp_phase != PH_PAYLOAD)
			return;
		// newline or full buffer closes the payload
		if (b == CH_NL || rsp_kept >= 5'(BUFFER_CHARS - 1)) begin
			rsp_phase = PH_DONE;
			if (rsp_colon)
				post_value(rsp_sat ? ST_SAT : ST_OK, rsp_mag, rsp_frac);
			return;
		end
		keep_byte(b);
	endtask

	// ---------------------------------------------------------------
	// driver, receiver and checker
	// ---------------------------------------------------------------

	// feed words from the send queue, with random gaps between them
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				parse_word(cmd, data);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (words_to_send.size() != 0) begin
					next_word = words_to_send.pop_front();
					cmd <= next_word.cmd;
					data <= next_word.data;
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// stall the result side in short bursts, and once for a long stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					stall_left <= $urandom_range(1, 10);
			end
		end
	end

	// compare each result word with the oldest predicted reading
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (readings_due.size() == 0) begin
				$display("%0t: result with none expected, actual status %0d mantissa %0d frac %0d",
					$time, status, mantissa, frac_digits);
				errors++;
			end else begin
				due = readings_due.pop_front();
				if (status !== due.status || mantissa !== due.mantissa ||
						frac_digits !== due.frac_digits) begin
					$display("%0t: expected status %0d mantissa %0d frac %0d", $time,
						due.status, $signed(due.mantissa), due.frac_digits);
					$display("%0t: actual   status %0d mantissa %0d frac %0d", $time,
						status, mantissa, frac_digits);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	task automatic put(input logic [1:0] c, input logic [7:0] b);
		rx_word_t w;
		w.cmd = c;
		w.data = b;
		words_to_send.push_back(w);
		queued++;
	endtask

	// a received byte, sometimes with a tick or an unused command ahead of it
	task automatic put_rx(input logic [7:0] b);
		case ($urandom_range(0, 15))
		0: put(CMD_TICK, 8'($urandom));
		1: put(CMD_UNUSED, 8'($urandom));
		default: ;
		endcase
		put(CMD_BYTE, b);
	endtask

	task automatic put_text(input string s, input bit noisy);
		for (int i = 0; i < s.len(); i++) begin
			if (noisy)
				put_rx(s[i]);
			else
				put(CMD_BYTE, s[i]);
		end
	endtask

	function automatic logic [7:0] any_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	// one tagged response, mostly well formed, with random content
	task automatic queue_exchange();
		logic [7:0]  tag;
		logic [7:0]  b;
		int unsigned shape;
		int unsigned n;
		shape = $urandom_range(0, 15);
		// mostly upper-case letters, sometimes any byte
		tag = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h41, 8'h5A)) : 8'($urandom);
		put(CMD_ARM, tag);
		// line noise ahead of the tagged response
		repeat ($urandom_range(0, 4)) begin
			b = 8'($urandom);
			put_rx((b == tag) ? ~b : b);
		end
		put_rx(tag);
		// label text ahead of the colon
		repeat ($urandom_range(0, 3))
			put_rx(8'($urandom_range(8'h61, 8'h7A)));
		if (shape == 0) begin
			// restart in the middle of a response
			put(CMD_ARM, tag);
			put_rx(tag);
		end
		if (shape != 1)
			put_rx(CH_COLON);
		repeat ($urandom_range(0, 2)) begin
			b = ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
			put_rx((b == CH_NL) ? CH_SPACE : b);
		end
		case ($urandom_range(0, 2))
		0: put_rx(CH_PLUS);
		1: put_rx(CH_MINUS);
		default: ;
		endcase
		// digits: near the mantissa limit, or random lengths
		case (shape)
		2: begin
			put_text("214748364", 1'b1);
			put_rx(any_digit());
		end
		3: begin
			put_text("21474836.4", 1'b1);
			repeat ($urandom_range(1, 3))
				put_rx(any_digit());
		end
		default: begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
			repeat (n)
				put_rx(any_digit());
			if ($urandom_range(0, 1) != 0) begin
				put_rx(CH_DOT);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
				repeat (n)
					put_rx(any_digit());
			end
		end
		endcase
		// trailing text: NUL, second colon or second point, each with a digit behind it
		case (shape)
		4: begin
			put_rx(CH_NUL);
			put_rx(any_digit());
		end
		5: begin
			put_rx(CH_COLON);
			put_rx(any_digit());
		end
		6: begin
			put_rx(CH_DOT);
			put_rx(any_digit());
		end
		default: ;
		endcase
		// close the response: overflow the buffer, run out the ticks, or newline
		if (shape == 7) begin
			repeat (32)
				put_rx(any_digit());
		end else if ((shape == 1 || shape == 8) && tmo_setting <= 16'd64) begin
			repeat (int'(tmo_setting) + 1)
				put(CMD_TICK, 8'($urandom));
		end else begin
			put_rx(CH_NL);
		end
	endtask

	task automatic run_exchanges();
		int unsigned start;
		start = queued;
		while (queued - start < WORDS_PER_PHASE)
			queue_exchange();
	endtask

	// wait until every word is sent and every reading is back, then drain
	task automatic wait_idle();
		do
			@(negedge clk);
		while (words_to_send.size() != 0 || in_valid || readings_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] ticks);
		cfg_valid <= 1'b1;
		timeout_ticks <= ticks;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tmo_setting = ticks;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// ignored words while disarmed, re-arm, a signed fraction
		put(CMD_UNUSED, 8'hFF);
		put(CMD_BYTE, 8'h54);
		put(CMD_TICK, 8'h00);
		put(CMD_ARM, 8'h58);
		put(CMD_ARM, 8'h54);
		put(CMD_BYTE, 8'hFF);
		put_text("T: -1.5\n", 1'b0);
		// NUL as the type character hides the colon behind it
		put(CMD_ARM, CH_NUL);
		put(CMD_BYTE, CH_NUL);
		put(CMD_BYTE, CH_COLON);
		put(CMD_BYTE, CH_NL);
		put(CMD_BYTE, CH_COLON);
		run_exchanges();

		foreach (timeout_plan[i]) begin
			wait_idle();
			write_timeout(timeout_plan[i]);
			// zero timeout: the first tick ends the wait
			if (timeout_plan[i] == 16'd0) begin
				put(CMD_ARM, 8'h5A);
				put(CMD_TICK, 8'h00);
			end
			if (i == 3)
				hold_go <= 1'b1;
			if (i == $size(timeout_plan) - 1)
				calm <= 1'b1;
			run_exchanges();
		end
		wait_idle();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// give up if the run hangs
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/tvrp_pkg.sv
design/tvrp_step.sv
design/tvrp_out.sv
design/tagged_value_response_parser_core.sv
bench/testbench.sv
